>>> sv/bmvr_pkg.sv
package bmvr_pkg;

  // fixed field widths of the word channels
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned BYTES_W    = 64;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned COPIES_W   = 4;
  localparam int unsigned ADDR_OUT_W = 32;
  localparam int unsigned STAT_W     = 40;
  localparam int unsigned BIT_CNT_W  = 4;

  // address lines that get low and high counters
  localparam int unsigned ADDR_LINES = 32;

  // copies that vote after reset
  localparam logic [COPIES_W-1:0] COPIES_RESET = 4'd3;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_VOTE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // statistic index map
  localparam logic [IDX_W-1:0] STAT_MISMATCH   = 7'd0;
  localparam logic [IDX_W-1:0] STAT_TIES       = 7'd1;
  localparam logic [IDX_W-1:0] STAT_BYTES      = 7'd2;
  localparam logic [IDX_W-1:0] STAT_LINE_FIRST = 7'd3;
  localparam logic [IDX_W-1:0] STAT_LINE_LAST  = 7'd10;
  localparam logic [IDX_W-1:0] STAT_HIST_FIRST = 7'd16;
  localparam logic [IDX_W-1:0] STAT_HIST_LAST  = 7'd23;
  localparam logic [IDX_W-1:0] STAT_LOW_FIRST  = 7'd32;
  localparam logic [IDX_W-1:0] STAT_LOW_LAST   = 7'd63;
  localparam logic [IDX_W-1:0] STAT_HIGH_FIRST = 7'd64;
  localparam logic [IDX_W-1:0] STAT_HIGH_LAST  = 7'd95;

  // outcome of one bitwise vote
  typedef struct packed {
    logic [7:0]                repaired;
    logic [7:0]                mism;
    logic [7:0]                ties;
    logic [7:0][BIT_CNT_W-1:0] zeros;
  } vote_t;

endpackage

>>> sv/bmvr_vote.sv
module bmvr_vote #(
  parameter int unsigned NUM_COPIES = 8
) (
  input  logic [bmvr_pkg::BYTES_W-1:0]   copy_bytes_i,
  input  logic [bmvr_pkg::COPIES_W-1:0]  copies_i,
  output bmvr_pkg::vote_t                vote_o
);

  // clamp the copy count to 1..NUM_COPIES
  logic [bmvr_pkg::COPIES_W-1:0] n_copies;

  always_comb begin
    if (copies_i == '0) begin
      n_copies = bmvr_pkg::COPIES_W'(1);
    end else if (copies_i > bmvr_pkg::COPIES_W'(NUM_COPIES)) begin
      n_copies = bmvr_pkg::COPIES_W'(NUM_COPIES);
    end else begin
      n_copies = copies_i;
    end
  end

  // per bit: count one votes of the active copies, then decide
  always_comb begin
    logic [bmvr_pkg::BIT_CNT_W-1:0] ones;
    logic [bmvr_pkg::BIT_CNT_W-1:0] zeros;
    vote_o = '0;
    for (int b = 0; b < 8; b++) begin
      ones = '0;
      for (int k = 0; k < NUM_COPIES; k++) begin
        if (bmvr_pkg::COPIES_W'(k) < n_copies && copy_bytes_i[8*k + b]) begin
          ones = ones + bmvr_pkg::BIT_CNT_W'(1);
        end
      end
      zeros = n_copies - ones;
      vote_o.zeros[b] = zeros;
      vote_o.mism[b]  = (ones != '0) && (zeros != '0);
      vote_o.ties[b]  = (ones == zeros);
      if (ones > zeros) begin
        vote_o.repaired[b] = 1'b1;
      end else if (zeros > ones) begin
        vote_o.repaired[b] = 1'b0;
      end else begin
        vote_o.repaired[b] = copy_bytes_i[b];
      end
    end
  end

endmodule

>>> sv/bitwise_majority_vote_repair.sv
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+----------------------------------------
// in      | input     | in_valid_i / in_stall_o  | command_i, copy_bytes_i, stat_index_i
// out     | output    | out_valid_o / out_stall_i| repaired_byte_o .. stat_value_o
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (copies_in_use)
//
// one word per cycle while the output is not stalled
// a taken word goes into the input register and its result into the result register
// the vote, the counter updates and the statistic read all sit between those two registers
// a stalled result holds the result register; the input register takes one more word
// and then stalls the input until the waiting result is taken
// reset clears all counters and the address and sets copies_in_use to three
module bitwise_majority_vote_repair #(
  parameter int unsigned NUM_COPIES  = 8,
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned COUNT_WIDTH = 40
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input words
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bmvr_pkg::CMD_W-1:0]       command_i,
  input  logic [bmvr_pkg::BYTES_W-1:0]     copy_bytes_i,
  input  logic [bmvr_pkg::IDX_W-1:0]       stat_index_i,
  // result words
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       repaired_byte_o,
  output logic [7:0]                       mismatch_mask_o,
  output logic [7:0]                       tie_mask_o,
  output logic [bmvr_pkg::ADDR_OUT_W-1:0]  byte_address_o,
  output logic [bmvr_pkg::STAT_W-1:0]      stat_value_o,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bmvr_pkg::COPIES_W-1:0]    cfg_data_i
);

  localparam int unsigned AddrExtW = (ADDR_BITS > bmvr_pkg::ADDR_OUT_W) ?
                                     ADDR_BITS : bmvr_pkg::ADDR_OUT_W;
  localparam int unsigned StatExtW = (COUNT_WIDTH > bmvr_pkg::STAT_W) ?
                                     COUNT_WIDTH : bmvr_pkg::STAT_W;

  // saturating add of a small increment
  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] c,
                                                     input logic [bmvr_pkg::BIT_CNT_W-1:0] n);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, c} + (COUNT_WIDTH+1)'(n);
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  // configuration register
  logic [bmvr_pkg::COPIES_W-1:0] copies_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copies_q <= bmvr_pkg::COPIES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      copies_q <= cfg_data_i;
    end
  end

  // pipeline control
  logic s1_valid_q, out_valid_q;
  logic advance, fire, in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // input register
  logic [bmvr_pkg::CMD_W-1:0]   s1_cmd_q;
  logic [bmvr_pkg::BYTES_W-1:0] s1_bytes_q;
  logic [bmvr_pkg::IDX_W-1:0]   s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q   <= command_i;
      s1_bytes_q <= copy_bytes_i;
      s1_idx_q   <= stat_index_i;
    end
  end

  // vote
  bmvr_pkg::vote_t vote;

  bmvr_vote #(
    .NUM_COPIES (NUM_COPIES)
  ) u_vote (
    .copy_bytes_i (s1_bytes_q),
    .copies_i     (copies_q),
    .vote_o       (vote)
  );

  // statistics state
  logic [ADDR_BITS-1:0]   addr_q, addr_d;
  logic [COUNT_WIDTH-1:0] mism_tot_q, mism_tot_d;
  logic [COUNT_WIDTH-1:0] tie_tot_q, tie_tot_d;
  logic [COUNT_WIDTH-1:0] byte_tot_q, byte_tot_d;
  logic [COUNT_WIDTH-1:0] line_cnt_q [8];
  logic [COUNT_WIDTH-1:0] line_cnt_d [8];
  logic [COUNT_WIDTH-1:0] hist_q [8];
  logic [COUNT_WIDTH-1:0] hist_d [8];
  logic [COUNT_WIDTH-1:0] alow_q [bmvr_pkg::ADDR_LINES];
  logic [COUNT_WIDTH-1:0] alow_d [bmvr_pkg::ADDR_LINES];
  logic [COUNT_WIDTH-1:0] ahigh_q [bmvr_pkg::ADDR_LINES];
  logic [COUNT_WIDTH-1:0] ahigh_d [bmvr_pkg::ADDR_LINES];

  logic [AddrExtW-1:0] addr_ext;
  assign addr_ext = AddrExtW'(addr_q);

  // increments from one vote
  logic [bmvr_pkg::BIT_CNT_W-1:0] mism_cnt, tie_cnt;
  logic [bmvr_pkg::BIT_CNT_W-1:0] hist_inc [8];

  always_comb begin
    mism_cnt = '0;
    tie_cnt  = '0;
    for (int h = 0; h < 8; h++) begin
      hist_inc[h] = '0;
    end
    for (int b = 0; b < 8; b++) begin
      if (vote.mism[b]) begin
        mism_cnt = mism_cnt + bmvr_pkg::BIT_CNT_W'(1);
        hist_inc[vote.zeros[b][2:0]] = hist_inc[vote.zeros[b][2:0]] +
                                       bmvr_pkg::BIT_CNT_W'(1);
        if (vote.ties[b]) begin
          tie_cnt = tie_cnt + bmvr_pkg::BIT_CNT_W'(1);
        end
      end
    end
  end

  // next state of the statistics
  always_comb begin
    addr_d     = addr_q;
    mism_tot_d = mism_tot_q;
    tie_tot_d  = tie_tot_q;
    byte_tot_d = byte_tot_q;
    line_cnt_d = line_cnt_q;
    hist_d     = hist_q;
    alow_d     = alow_q;
    ahigh_d    = ahigh_q;
    if (fire) begin
      case (s1_cmd_q)
        bmvr_pkg::CMD_VOTE: begin
          addr_d     = addr_q + ADDR_BITS'(1);
          mism_tot_d = sat_add(mism_tot_q, mism_cnt);
          tie_tot_d  = sat_add(tie_tot_q, tie_cnt);
          byte_tot_d = sat_add(byte_tot_q, bmvr_pkg::BIT_CNT_W'(1));
          for (int b = 0; b < 8; b++) begin
            line_cnt_d[b] = sat_add(line_cnt_q[b], bmvr_pkg::BIT_CNT_W'(vote.mism[b]));
            hist_d[b]     = sat_add(hist_q[b], hist_inc[b]);
          end
          for (int l = 0; l < bmvr_pkg::ADDR_LINES; l++) begin
            if (l < ADDR_BITS) begin
              if (addr_ext[l]) begin
                ahigh_d[l] = sat_add(ahigh_q[l], mism_cnt);
              end else begin
                alow_d[l] = sat_add(alow_q[l], mism_cnt);
              end
            end
          end
        end
        bmvr_pkg::CMD_CLEAR: begin
          addr_d     = '0;
          mism_tot_d = '0;
          tie_tot_d  = '0;
          byte_tot_d = '0;
          for (int b = 0; b < 8; b++) begin
            line_cnt_d[b] = '0;
            hist_d[b]     = '0;
          end
          for (int l = 0; l < bmvr_pkg::ADDR_LINES; l++) begin
            alow_d[l]  = '0;
            ahigh_d[l] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      mism_tot_q <= '0;
      tie_tot_q  <= '0;
      byte_tot_q <= '0;
      for (int b = 0; b < 8; b++) begin
        line_cnt_q[b] <= '0;
        hist_q[b]     <= '0;
      end
      for (int l = 0; l < bmvr_pkg::ADDR_LINES; l++) begin
        alow_q[l]  <= '0;
        ahigh_q[l] <= '0;
      end
    end else begin
      addr_q     <= addr_d;
      mism_tot_q <= mism_tot_d;
      tie_tot_q  <= tie_tot_d;
      byte_tot_q <= byte_tot_d;
      line_cnt_q <= line_cnt_d;
      hist_q     <= hist_d;
      alow_q     <= alow_d;
      ahigh_q    <= ahigh_d;
    end
  end

  // statistic read
  logic [COUNT_WIDTH-1:0] rd_val;
  logic [StatExtW-1:0]    rd_ext;

  always_comb begin
    logic [bmvr_pkg::IDX_W-1:0] line_off;
    line_off = s1_idx_q - bmvr_pkg::STAT_LINE_FIRST;
    case (s1_idx_q) inside
      bmvr_pkg::STAT_MISMATCH: rd_val = mism_tot_q;
      bmvr_pkg::STAT_TIES:     rd_val = tie_tot_q;
      bmvr_pkg::STAT_BYTES:    rd_val = byte_tot_q;
      [bmvr_pkg::STAT_LINE_FIRST:bmvr_pkg::STAT_LINE_LAST]: rd_val = line_cnt_q[line_off[2:0]];
      [bmvr_pkg::STAT_HIST_FIRST:bmvr_pkg::STAT_HIST_LAST]: rd_val = hist_q[s1_idx_q[2:0]];
      [bmvr_pkg::STAT_LOW_FIRST:bmvr_pkg::STAT_LOW_LAST]:   rd_val = alow_q[s1_idx_q[4:0]];
      [bmvr_pkg::STAT_HIGH_FIRST:bmvr_pkg::STAT_HIGH_LAST]: rd_val = ahigh_q[s1_idx_q[4:0]];
      default: rd_val = '0;
    endcase
  end

  assign rd_ext = StatExtW'(rd_val);

  // result word
  logic [7:0]                      res_rep_d, res_mism_d, res_tie_d;
  logic [bmvr_pkg::ADDR_OUT_W-1:0] res_addr_d;
  logic [bmvr_pkg::STAT_W-1:0]     res_stat_d;
  logic [7:0]                      res_rep_q, res_mism_q, res_tie_q;
  logic [bmvr_pkg::ADDR_OUT_W-1:0] res_addr_q;
  logic [bmvr_pkg::STAT_W-1:0]     res_stat_q;

  always_comb begin
    res_rep_d  = '0;
    res_mism_d = '0;
    res_tie_d  = '0;
    res_addr_d = '0;
    res_stat_d = '0;
    case (s1_cmd_q)
      bmvr_pkg::CMD_VOTE: begin
        res_rep_d  = vote.repaired;
        res_mism_d = vote.mism;
        res_tie_d  = vote.ties & vote.mism;
        res_addr_d = addr_ext[bmvr_pkg::ADDR_OUT_W-1:0];
      end
      bmvr_pkg::CMD_READ: begin
        res_stat_d = rd_ext[bmvr_pkg::STAT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_rep_q  <= res_rep_d;
      res_mism_q <= res_mism_d;
      res_tie_q  <= res_tie_d;
      res_addr_q <= res_addr_d;
      res_stat_q <= res_stat_d;
    end
  end

  assign repaired_byte_o = res_rep_q;
  assign mismatch_mask_o = res_mism_q;
  assign tie_mask_o      = res_tie_q;
  assign byte_address_o  = res_addr_q;
  assign stat_value_o    = res_stat_q;

endmodule

>>> tb/bitwise_majority_vote_repair_tb.sv
module bitwise_majority_vote_repair_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bmvr_pkg::CMD_W-1:0]  CMD_UNKNOWN = 2'd3;
  localparam logic [bmvr_pkg::STAT_W-1:0] COUNT_MAX   = '1;
  localparam int unsigned       NUM_VOTERS  = 8;
  localparam int unsigned       PHASES      = 12;
  localparam int unsigned       RAND_WORDS  = 165;
  localparam int unsigned       CYCLE_LIMIT = 300000;

  typedef struct {
    logic [bmvr_pkg::CMD_W-1:0]   cmd;
    logic [bmvr_pkg::BYTES_W-1:0] bytes;
    logic [bmvr_pkg::IDX_W-1:0]   idx;
  } in_word_t;

  typedef struct {
    logic [7:0]                      repaired;
    logic [7:0]                      mism;
    logic [7:0]                      ties;
    logic [bmvr_pkg::ADDR_OUT_W-1:0] addr;
    logic [bmvr_pkg::STAT_W-1:0]     stat;
  } out_word_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // block ports
  logic                            in_valid   = 1'b0;
  logic                            in_stall;
  logic [bmvr_pkg::CMD_W-1:0]      command    = '0;
  logic [bmvr_pkg::BYTES_W-1:0]    copy_bytes = '0;
  logic [bmvr_pkg::IDX_W-1:0]      stat_index = '0;
  logic                            out_valid;
  logic                            out_stall  = 1'b0;
  logic [7:0]                      repaired_byte;
  logic [7:0]                      mismatch_mask;
  logic [7:0]                      tie_mask;
  logic [bmvr_pkg::ADDR_OUT_W-1:0] byte_address;
  logic [bmvr_pkg::STAT_W-1:0]     stat_value;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [bmvr_pkg::COPIES_W-1:0]   cfg_data   = '0;

  bitwise_majority_vote_repair u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .copy_bytes_i    (copy_bytes),
    .stat_index_i    (stat_index),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .repaired_byte_o (repaired_byte),
    .mismatch_mask_o (mismatch_mask),
    .tie_mask_o      (tie_mask),
    .byte_address_o  (byte_address),
    .stat_value_o    (stat_value),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  // voter state mirrored by the testbench
  logic [bmvr_pkg::COPIES_W-1:0]   copies_cfg = bmvr_pkg::COPIES_RESET;
  logic [bmvr_pkg::ADDR_OUT_W-1:0] next_addr;
  logic [bmvr_pkg::STAT_W-1:0]     mismatch_total;
  logic [bmvr_pkg::STAT_W-1:0]     tie_total;
  logic [bmvr_pkg::STAT_W-1:0]     byte_total;
  logic [bmvr_pkg::STAT_W-1:0]     line_cnt  [8];
  logic [bmvr_pkg::STAT_W-1:0]     zero_hist [8];
  logic [bmvr_pkg::STAT_W-1:0]     low_cnt   [bmvr_pkg::ADDR_LINES];
  logic [bmvr_pkg::STAT_W-1:0]     high_cnt  [bmvr_pkg::ADDR_LINES];

  in_word_t    pending_words[$];
  out_word_t   awaited_results[$];
  in_word_t    cur_word;
  out_word_t   got_word;
  out_word_t   want_word;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned err_count     = 0;
  int unsigned results_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned cycle_count   = 0;
  int unsigned words_by_cmd [4];

  function automatic logic [bmvr_pkg::STAT_W-1:0] sat_inc(logic [bmvr_pkg::STAT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void clear_counters();
    next_addr      = '0;
    mismatch_total = '0;
    tie_total      = '0;
    byte_total     = '0;
    foreach (line_cnt[i]) line_cnt[i] = '0;
    foreach (zero_hist[i]) zero_hist[i] = '0;
    foreach (low_cnt[i]) low_cnt[i] = '0;
    foreach (high_cnt[i]) high_cnt[i] = '0;
  endfunction

  // expected result of one word, updating the mirrored counters
  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    int        n;
    int        ones;
    int        zeros;
    r = '{default: '0};
    case (w.cmd)
      bmvr_pkg::CMD_READ: begin
        if (w.idx == bmvr_pkg::STAT_MISMATCH) r.stat = mismatch_total;
        else if (w.idx == bmvr_pkg::STAT_TIES) r.stat = tie_total;
        else if (w.idx == bmvr_pkg::STAT_BYTES) r.stat = byte_total;
        else if (w.idx >= bmvr_pkg::STAT_LINE_FIRST && w.idx <= bmvr_pkg::STAT_LINE_LAST)
          r.stat = line_cnt[w.idx - bmvr_pkg::STAT_LINE_FIRST];
        else if (w.idx >= bmvr_pkg::STAT_HIST_FIRST && w.idx <= bmvr_pkg::STAT_HIST_LAST)
          r.stat = zero_hist[w.idx - bmvr_pkg::STAT_HIST_FIRST];
        else if (w.idx >= bmvr_pkg::STAT_LOW_FIRST && w.idx <= bmvr_pkg::STAT_LOW_LAST)
          r.stat = low_cnt[w.idx - bmvr_pkg::STAT_LOW_FIRST];
        else if (w.idx >= bmvr_pkg::STAT_HIGH_FIRST && w.idx <= bmvr_pkg::STAT_HIGH_LAST)
          r.stat = high_cnt[w.idx - bmvr_pkg::STAT_HIGH_FIRST];
      end
      bmvr_pkg::CMD_CLEAR: clear_counters();
      bmvr_pkg::CMD_VOTE: begin
        // out of range copy counts clamp to one and to the full set
        if (copies_cfg == 0) n = 1;
        else if (copies_cfg > NUM_VOTERS) n = NUM_VOTERS;
        else n = int'(copies_cfg);
        r.repaired = w.bytes[7:0];
        r.addr     = next_addr;
        for (int b = 0; b < 8; b++) begin
          ones = 0;
          for (int k = 0; k < n; k++) ones += int'(w.bytes[8*k + b]);
          zeros = n - ones;
          if (ones != 0 && zeros != 0) begin
            r.mism[b] = 1'b1;
            if (zeros > ones) r.repaired[b] = 1'b0;
            else if (ones > zeros) r.repaired[b] = 1'b1;
            else begin
              // tie keeps the copy 0 bit
              r.ties[b] = 1'b1;
              tie_total = sat_inc(tie_total);
            end
            mismatch_total       = sat_inc(mismatch_total);
            zero_hist[zeros % 8] = sat_inc(zero_hist[zeros % 8]);
            line_cnt[b]          = sat_inc(line_cnt[b]);
            for (int ln = 0; ln < bmvr_pkg::ADDR_LINES; ln++) begin
              if (next_addr[ln]) high_cnt[ln] = sat_inc(high_cnt[ln]);
              else low_cnt[ln] = sat_inc(low_cnt[ln]);
            end
          end
        end
        byte_total = sat_inc(byte_total);
        next_addr  = next_addr + 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string field, logic [bmvr_pkg::STAT_W-1:0] want_v,
                                      logic [bmvr_pkg::STAT_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want_v, got_v);
      err_count++;
    end
  endfunction

  // input driver, fed from the pending word queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_word(cur_word));
        words_by_cmd[cur_word.cmd]++;
      end
      // a stalled word stays put
      if (!(in_valid && in_stall)) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = pending_words.pop_front();
          in_valid   <= 1'b1;
          command    <= cur_word.cmd;
          copy_bytes <= cur_word.bytes;
          stat_index <= cur_word.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and random output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_word = '{repaired_byte, mismatch_mask, tie_mask, byte_address, stat_value};
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with nothing pending, repaired 0x%0h stat 0x%0h",
                   $time, repaired_byte, stat_value);
          err_count++;
        end else begin
          want_word = awaited_results.pop_front();
          check_field("repaired_byte", bmvr_pkg::STAT_W'(want_word.repaired),
                      bmvr_pkg::STAT_W'(got_word.repaired));
          check_field("mismatch_mask", bmvr_pkg::STAT_W'(want_word.mism),
                      bmvr_pkg::STAT_W'(got_word.mism));
          check_field("tie_mask", bmvr_pkg::STAT_W'(want_word.ties),
                      bmvr_pkg::STAT_W'(got_word.ties));
          check_field("byte_address", bmvr_pkg::STAT_W'(want_word.addr),
                      bmvr_pkg::STAT_W'(got_word.addr));
          check_field("stat_value", want_word.stat, got_word.stat);
          results_seen++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, awaited_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_word(logic [bmvr_pkg::CMD_W-1:0] cmd, logic [bmvr_pkg::BYTES_W-1:0] bytes,
                           logic [bmvr_pkg::IDX_W-1:0] idx);
    pending_words.push_back('{cmd, bytes, idx});
  endtask

  // wait until every word is through, then let the pipeline settle
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_copies(logic [bmvr_pkg::COPIES_W-1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    copies_cfg = v;
    cfg_writes++;
  endtask

  // stimulus
  initial begin
    logic [bmvr_pkg::COPIES_W-1:0] copies_plan [PHASES];
    logic [bmvr_pkg::CMD_W-1:0]    cmd;
    logic [bmvr_pkg::BYTES_W-1:0]  bytes;
    logic [7:0]                    base;
    int                            pick;

    copies_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd2, 4'd7, 4'd9, 4'd5, 4'd6, 4'd3, 4'd8};
    copies_plan[PHASES-1] = bmvr_pkg::COPIES_W'($urandom_range(15));
    clear_counters();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 67;

    // directed words with the reset copy count of three
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_BYTES);
    push_word(bmvr_pkg::CMD_VOTE, '0, '0);
    push_word(bmvr_pkg::CMD_VOTE, '1, '1);
    push_word(bmvr_pkg::CMD_VOTE, 64'h0000_0000_0000_00FF, '0);
    push_word(bmvr_pkg::CMD_VOTE, 64'h0000_0000_00FF_FF00, '0);
    // bytes of unused copies are ignored
    push_word(bmvr_pkg::CMD_VOTE, 64'hFFFF_FFFF_FF00_0000, '0);
    push_word(bmvr_pkg::CMD_VOTE, 64'h0000_0000_0081_0000, '0);
    push_word(CMD_UNKNOWN, '1, '1);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_MISMATCH);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_TIES);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_BYTES);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_LINE_FIRST);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_LINE_LAST);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_HIST_FIRST + 7'd1);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_HIST_FIRST + 7'd2);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_HIST_LAST);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_LOW_FIRST);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_LOW_LAST);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_HIGH_FIRST);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_HIGH_LAST);
    // unassigned statistic indexes
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_LINE_LAST + 7'd1);
    push_word(bmvr_pkg::CMD_READ, '1, '1);
    push_word(bmvr_pkg::CMD_CLEAR, '1, '1);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_MISMATCH);
    push_word(bmvr_pkg::CMD_VOTE, 64'h0000_0000_0001_0100, '0);
    drain();

    // two copies give ties
    write_copies(4'd2);
    push_word(bmvr_pkg::CMD_VOTE, 64'h0000_0000_0000_F00F, '0);
    push_word(bmvr_pkg::CMD_VOTE, 64'hFFFF_FFFF_FFFF_00F0, '0);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_TIES);
    push_word(bmvr_pkg::CMD_READ, '0, bmvr_pkg::STAT_HIST_FIRST + 7'd1);
    drain();

    // random phases over several copy counts and idle mixes
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 32;
      end else if (ph == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_copies(copies_plan[ph]);
      for (int i = 0; i < RAND_WORDS; i++) begin
        pick = $urandom_range(99);
        if (pick < 78) cmd = bmvr_pkg::CMD_VOTE;
        else if (pick < 90) cmd = bmvr_pkg::CMD_READ;
        else if (pick < 93) cmd = bmvr_pkg::CMD_CLEAR;
        else cmd = CMD_UNKNOWN;
        // mostly near-agreeing copies, some fully random
        base  = 8'($urandom_range(255));
        bytes = {8{base}};
        case ($urandom_range(2))
          0: bytes = {$urandom, $urandom};
          1: begin
            for (int k = 0; k < NUM_VOTERS; k++)
              bytes[8*k +: 8] = bytes[8*k +: 8] ^ 8'($urandom & $urandom & $urandom);
          end
          default: bytes[8*$urandom_range(7) +: 8] = 8'($urandom_range(255));
        endcase
        push_word(cmd, bytes, bmvr_pkg::IDX_W'($urandom_range(127)));
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("run covered %0d votes, %0d reads, %0d clears, %0d unknown commands",
             words_by_cmd[bmvr_pkg::CMD_VOTE], words_by_cmd[bmvr_pkg::CMD_READ],
             words_by_cmd[bmvr_pkg::CMD_CLEAR], words_by_cmd[CMD_UNKNOWN]);
    $display("copy count written %0d times, %0d result words checked, %0d errors",
             cfg_writes, results_seen, err_count);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
